// ===== rtl/core/fbc_pkg.sv =====
// Shared types and constants for the block FIR convolver.
// No dependencies; imported by fbc_cell, fbc_mac and fir_block_convolver.
package fbc_pkg;

  localparam int DATA_W      = 16;  // Q1.15 samples and coefficients
  localparam int IDX_W       = 5;   // coefficient index field
  localparam int PROD_W      = 32;  // exact Q2.30 product
  localparam int ROUND_SHIFT = 27;  // Q.42 -> Q.15

  localparam logic signed [DATA_W-1:0] GAIN_RESET = 16'sd4096;  // unity in Q4.12

  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_PUSH = 1'b1;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t                   op;
    logic signed [DATA_W-1:0]   coef_data;
  } cell_ctrl_t;

  typedef struct packed {
    logic valid;
    logic first;
  } mac_issue_t;

endpackage

// ===== rtl/core/fbc_cell.sv =====
// One cell of the tap chain: a coefficient and a delay-line sample.
// Depends on fbc_pkg.
module fbc_cell
  import fbc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cell_ctrl_t               ctrl,
  input  logic                     coef_we,
  input  logic signed [DATA_W-1:0] left_sample,
  input  logic signed [DATA_W-1:0] right_sample,
  input  logic signed [DATA_W-1:0] right_coef,
  output logic signed [DATA_W-1:0] coef,
  output logic signed [DATA_W-1:0] sample
);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef   <= '0;
      sample <= '0;
    end else begin
      unique case (ctrl.op)
        CELL_HOLD: ;
        CELL_SHIFT: begin
          sample <= left_sample;
        end
        CELL_ROTATE: begin
          sample <= right_sample;
          coef   <= right_coef;
        end
        default: ;
      endcase
      // loads only happen while the chain is at rest
      if (coef_we) begin
        coef <= ctrl.coef_data;
      end
    end
  end

endmodule

// ===== rtl/core/fbc_mac.sv =====
// Shared multiply-accumulate, gain multiply, rounding and saturation.
// Depends on fbc_pkg.
module fbc_mac
  import fbc_pkg::*;
#(
  parameter int ACC_W = 37
) (
  input  logic                     clk,
  input  logic                     rst,
  input  mac_issue_t               issue,
  input  logic signed [DATA_W-1:0] coef,
  input  logic signed [DATA_W-1:0] sample,
  input  logic                     scale_en,
  input  logic signed [DATA_W-1:0] gain,
  output logic signed [DATA_W-1:0] result
);

  localparam int SW = ACC_W + DATA_W;
  localparam logic signed [SW-1:0] RND_HALF = SW'(1) <<< (ROUND_SHIFT - 1);
  localparam logic signed [SW-1:0] SAT_HI   = SW'(32767);
  localparam logic signed [SW-1:0] SAT_LO   = SW'(-32768);

  logic signed [PROD_W-1:0] prod;
  logic                     prod_valid;
  logic                     prod_first;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SW-1:0]     scaled;
  logic signed [SW-1:0]     rounded;
  logic signed [SW-1:0]     shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      prod_first <= 1'b0;
    end else begin
      prod_valid <= issue.valid;
      prod_first <= issue.first;
    end
  end

  always_ff @(posedge clk) begin
    prod <= coef * sample;
    if (prod_valid) begin
      acc <= prod_first ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
    if (scale_en) begin
      scaled <= acc * gain;
    end
  end

  // round half up, then clamp to Q1.15
  always_comb begin
    rounded = scaled + RND_HALF;
    shifted = rounded >>> ROUND_SHIFT;
    priority if (shifted > SAT_HI) begin
      result = SAT_HI[DATA_W-1:0];
    end else if (shifted < SAT_LO) begin
      result = SAT_LO[DATA_W-1:0];
    end else begin
      result = shifted[DATA_W-1:0];
    end
  end

endmodule

// ===== rtl/core/fir_block_convolver.sv =====
// Top level of the block FIR convolver: tap chain, sequencer, output register.
// Depends on fbc_pkg, fbc_cell and fbc_mac.
//
// Input channel (in_valid/in_ready): one word carries action, tap_index,
// value and block_end. A load word (action 0) writes coefficient tap_index
// in the accept cycle and produces nothing; indexes >= TAPS are dropped.
// A push word (action 1) shifts value into the delay line and produces one
// output word; with block_end set it produces TAPS words in all, the tail
// formed by shifting in zeros, with final_of_block on the last one.
// Output channel (out_valid/out_ready): filtered and final_of_block.
// Configuration: cfg_we writes output_gain (Q4.12) from cfg_wdata.
// Sequence: each output walks the coefficient/sample ring once through the
// single shared multiplier, then passes the drain, gain and emit states.
// Loads leave in_ready high; in_ready is low while a push or tail runs.
// Reset: coefficients, delay line and out_valid clear, gain = unity.
// Stall: a full output register holds its word; the emit step waits, and
// the next push is still taken while the last word sits unread.
module fir_block_convolver
  import fbc_pkg::*;
#(
  parameter int TAPS = 31
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     action,
  input  logic [IDX_W-1:0]         tap_index,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     block_end,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] filtered,
  output logic                     final_of_block,
  input  logic                     cfg_we,
  input  logic signed [DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(TAPS);
  localparam int ACC_W = PROD_W + $clog2(TAPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_DRAIN,
    ST_SCALE,
    ST_EMIT
  } state_t;

  state_t                   state;
  logic [CNT_W-1:0]         cnt;        // ring position during the walk
  logic [CNT_W-1:0]         tail_left;  // tail words still to form
  logic                     blk;        // current push closes a block
  logic signed [DATA_W-1:0] output_gain;

  logic                     accept;
  logic                     push_acc;
  logic                     load_acc;
  logic                     emit_ok;
  logic                     tail_shift;
  logic signed [DATA_W-1:0] shift_data;
  cell_ctrl_t               cell_ctrl;
  mac_issue_t               issue;
  logic                     scale_en;
  logic signed [DATA_W-1:0] result;

  logic signed [DATA_W-1:0] coef_q   [TAPS];
  logic signed [DATA_W-1:0] sample_q [TAPS];
  logic [TAPS-1:0]          coef_we;

  assign in_ready   = (state == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign push_acc   = accept && (action == ACTION_PUSH);
  assign load_acc   = accept && (action == ACTION_LOAD) && (32'(tap_index) < TAPS);
  assign emit_ok    = (state == ST_EMIT) && (!out_valid || out_ready);
  assign tail_shift = emit_ok && (tail_left != '0);
  assign shift_data = push_acc ? value : '0;  // tail feeds zeros

  always_comb begin
    cell_ctrl.coef_data = value;
    priority if (push_acc || tail_shift) begin
      cell_ctrl.op = CELL_SHIFT;
    end else if (state == ST_ROT) begin
      cell_ctrl.op = CELL_ROTATE;
    end else begin
      cell_ctrl.op = CELL_HOLD;
    end
  end

  assign issue.valid = (state == ST_ROT);
  assign issue.first = (cnt == '0);
  assign scale_en    = (state == ST_SCALE);

  // Chain: shift moves samples toward the far end, rotate moves both
  // fields one step toward cell 0, wrapping, so TAPS steps restore it.
  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    localparam int LEFT  = (k == 0) ? 0 : k - 1;
    localparam int RIGHT = (k == TAPS - 1) ? 0 : k + 1;

    assign coef_we[k] = load_acc && (32'(tap_index) == k);

    fbc_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (cell_ctrl),
      .coef_we      (coef_we[k]),
      .left_sample  ((k == 0) ? shift_data : sample_q[LEFT]),
      .right_sample (sample_q[RIGHT]),
      .right_coef   (coef_q[RIGHT]),
      .coef         (coef_q[k]),
      .sample       (sample_q[k])
    );
  end

  fbc_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .issue    (issue),
    .coef     (coef_q[0]),
    .sample   (sample_q[0]),
    .scale_en (scale_en),
    .gain     (output_gain),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      tail_left   <= '0;
      blk         <= 1'b0;
      out_valid   <= 1'b0;
      output_gain <= GAIN_RESET;
    end else begin
      if (cfg_we) begin
        output_gain <= cfg_wdata;
      end
      // a taken word empties the register unless the emit step refills it
      if (out_valid && out_ready && !emit_ok) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (push_acc) begin
            state     <= ST_ROT;
            cnt       <= '0;
            tail_left <= block_end ? CNT_W'(TAPS - 1) : '0;
            blk       <= block_end;
          end
        end
        ST_ROT: begin
          if (cnt == CNT_W'(TAPS - 1)) begin
            cnt   <= '0;
            state <= ST_DRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DRAIN: begin
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_ok) begin
            out_valid      <= 1'b1;
            filtered       <= result;
            final_of_block <= blk && (tail_left == '0);
            if (tail_left != '0) begin
              tail_left <= tail_left - 1'b1;
              cnt       <= '0;
              state     <= ST_ROT;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/fbc_checker.sv =====
// Port-level checks for the block FIR convolver, bound to the top level.
// Depends on fir_block_convolver port names only.
module fbc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        action,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] filtered,
  input logic        final_of_block
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered) && $stable(final_of_block))
    else $error("output word changed while stalled");

  // a push occupies the block, so the next word waits
  a_push_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action |=> !in_ready)
    else $error("input taken during push processing");

  // coefficient loads finish in their accept cycle
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !action |=> in_ready)
    else $error("load stalled the input");

  // reset leaves nothing pending and the input open
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("state not cleared by reset");

endmodule

bind fir_block_convolver fbc_checker u_fbc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .action         (action),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .filtered       (filtered),
  .final_of_block (final_of_block)
);
